>>> sv/swpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpd_pkg
// Shared types and constants of the sync word packet deframer.
// ----------------------------------------------------------------------------
package swpd_pkg;

   localparam logic [31:0] SYNC_WORD_RESET  = 32'h91EB_FA58;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SYNC_WORD  = 1'b0,
      CSR_MAX_LENGTH = 1'b1
   } csr_addr_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEN_LO = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_BODY   = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      K_BODY  = 2'd0,
      K_GOOD  = 2'd1,
      K_BAD   = 2'd2,
      K_ABORT = 2'd3
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
   } rsp_type;

endpackage

>>> sv/swpd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpd_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module swpd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // rx_byte
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = (valid_ff && !advance) || req_tvalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

>>> sv/swpd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpd_frame
// Sync matcher and frame phase logic; one byte per step.
// ----------------------------------------------------------------------------
module swpd_frame (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic [31:0]      sync_word,
   input  logic [15:0]      max_length,
   output swpd_pkg::rsp_type rsp
);
   import swpd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  match_ff, match_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;

   logic [7:0]  want;
   logic        hit;
   logic [15:0] len_full;
   logic [15:0] count_next;

   always_comb begin
      unique case (match_ff)
         2'd0:    want = sync_word[31:24];
         2'd1:    want = sync_word[23:16];
         2'd2:    want = sync_word[15:8];
         default: want = sync_word[7:0];
      endcase
   end

   assign hit        = (rx_byte == want);
   assign len_full   = {rx_byte, len_ff[7:0]};
   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      match_in = hit ? match_ff + 2'd1 : 2'd0;
      xor_in   = xor_ff;
      len_in   = len_ff;
      count_in = count_ff;
      rsp      = '0;
      if (hit && match_ff == 2'd3) begin
         // sync complete: abort any open frame and start a new one
         rsp.valid        = (phase_ff != PH_IDLE);
         rsp.kind         = K_ABORT;
         rsp.frame_length = len_ff;
         match_in = 2'd0;
         phase_in = PH_LEN_LO;
         xor_in   = '0;
         len_in   = '0;
         count_in = '0;
      end else begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               len_in   = {8'd0, rx_byte};
               xor_in   = xor_ff ^ rx_byte;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in = len_full;
               xor_in = xor_ff ^ rx_byte;
               if (len_full == 16'd0 || len_full > max_length) begin
                  phase_in = PH_IDLE;
                  match_in = 2'd0;
               end else begin
                  phase_in = PH_BODY;
                  count_in = '0;
               end
            end
            PH_BODY: begin
               rsp.valid        = 1'b1;
               rsp.kind         = K_BODY;
               rsp.data_byte    = rx_byte;
               rsp.byte_index   = count_ff;
               rsp.frame_length = len_ff;
               count_in = count_next;
               xor_in   = xor_ff ^ rx_byte;
               if (count_next == len_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               rsp.valid        = 1'b1;
               rsp.kind         = (rx_byte == xor_ff) ? K_GOOD : K_BAD;
               rsp.frame_length = len_ff;
               phase_in = PH_IDLE;
               match_in = 2'd0;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         match_ff <= '0;
         xor_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         xor_ff   <= xor_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/swpd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpd_out_stage
// Result register driving the rsp stream.
// ----------------------------------------------------------------------------
module swpd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  swpd_pkg::rsp_type rsp,
   output logic              can_load,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // data_byte, byte_index, frame_length
   output logic [1:0]        rsp_tuser    // kind
);
   import swpd_pkg::*;

   logic        valid_ff, valid_in;
   kind_type    kind_ff;
   logic [7:0]  data_ff;
   logic [15:0] index_ff;
   logic [15:0] length_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = rsp.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && rsp.valid) begin
         kind_ff   <= rsp.kind;
         data_ff   <= rsp.data_byte;
         index_ff  <= rsp.byte_index;
         length_ff <= rsp.frame_length;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {length_ff, index_ff, data_ff};
   assign rsp_tuser  = kind_ff;

endmodule

>>> sv/sync_word_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_unit
// Byte stream deframer: sync word, length, body, xor checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per item and gives at most one result per byte:
// a body byte with its index, a good or bad checksum report, or an abort when
// a new sync word arrives inside a frame. Throughput is one byte per clock
// unless rsp_tready stalls the output; a byte waits in the input register
// and its result is then loaded into the output register. The whole frame
// update (sync compare, xor, length check, counter) fits between the two
// registers. Write csr registers only while the stream is idle.
module sync_word_packet_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // data_byte, byte_index, frame_length
   output logic [1:0]  rsp_tuser,    // kind
   input  logic        csr_we,
   input  logic [swpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [swpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import swpd_pkg::*;

   logic [31:0] sync_word_ff;
   logic [15:0] max_length_ff;

   logic        item_valid;
   logic [7:0]  item_byte;
   logic        can_load;
   logic        step;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff  <= SYNC_WORD_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_SYNC_WORD:  sync_word_ff  <= csr_wdata[31:0];
            CSR_MAX_LENGTH: max_length_ff <= csr_wdata[15:0];
            default:        ;
         endcase
      end
   end

   assign step = item_valid && can_load;

   swpd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (step),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   swpd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (item_byte),
      .sync_word  (sync_word_ff),
      .max_length (max_length_ff),
      .rsp        (rsp)
   );

   swpd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .rsp        (rsp),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> bench/sync_word_packet_deframer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_unit_test
// Self-checking bench for the sync word packet deframer.
// ----------------------------------------------------------------------------
// A short table of hand-built frames runs first: a bad checksum, an abort
// raised by a sync word that arrives inside a frame, and a good frame. Random
// byte streams follow. Most are well-formed frames with random bodies, and
// the rest are noise, cut-off frames and bad lengths. They run under several
// register settings and under several mixes of sender gaps and receiver
// stalls. Each accepted byte goes through a local deframer model, and each
// result is compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_unit_test;
   import swpd_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
   } deframer_out_t;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_QUIET,
      ROW_TYPED
   } row_mode_t;

   typedef struct packed {
      logic [7:0]    rx;
      row_mode_t     mode;
      deframer_out_t res;
   } stim_row_t;

   typedef struct packed {
      logic [31:0] sync_word;
      logic [15:0] max_length;
      int          send_idle_pct;
      int          stall_pct;
      int          byte_count;
   } run_plan_t;

   localparam deframer_out_t NO_RESULT = '{K_BODY, 8'h00, 16'd0, 16'd0};
   localparam int SETTLE_CYCLES = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = CSR_SYNC_WORD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // deframer model state and its copy of the registers
   logic [31:0] cfg_sync;
   logic [15:0] cfg_max;
   phase_type   fr_phase;
   int unsigned match_count;
   logic [7:0]  run_xor;
   logic [15:0] decl_len;
   logic [15:0] body_cnt;

   deframer_out_t pending_results[$];
   int error_count   = 0;
   int bytes_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   stim_row_t frame_rows [23] = '{
      '{8'h91, ROW_QUIET, NO_RESULT},
      '{8'hEB, ROW_QUIET, NO_RESULT},
      '{8'hFA, ROW_QUIET, NO_RESULT},
      '{8'h58, ROW_QUIET, NO_RESULT},
      '{8'h02, ROW_QUIET, NO_RESULT},
      '{8'h00, ROW_QUIET, NO_RESULT},
      '{8'h00, ROW_TYPED, '{K_BODY, 8'h00, 16'd0, 16'd2}},
      '{8'hFF, ROW_TYPED, '{K_BODY, 8'hFF, 16'd1, 16'd2}},
      // checksum should be 8'hFD
      '{8'h00, ROW_TYPED, '{K_BAD, 8'h00, 16'd0, 16'd2}},
      '{8'h91, ROW_QUIET, NO_RESULT},
      '{8'hEB, ROW_QUIET, NO_RESULT},
      '{8'hFA, ROW_QUIET, NO_RESULT},
      '{8'h58, ROW_QUIET, NO_RESULT},
      '{8'h03, ROW_QUIET, NO_RESULT},
      '{8'h00, ROW_QUIET, NO_RESULT},
      // sync bytes carried as body data
      '{8'h91, ROW_PREDICT, NO_RESULT},
      '{8'hEB, ROW_PREDICT, NO_RESULT},
      '{8'hFA, ROW_PREDICT, NO_RESULT},
      // completes the sync in the checksum phase
      '{8'h58, ROW_TYPED, '{K_ABORT, 8'h00, 16'd0, 16'd3}},
      '{8'h01, ROW_QUIET, NO_RESULT},
      '{8'h00, ROW_QUIET, NO_RESULT},
      '{8'hA5, ROW_TYPED, '{K_BODY, 8'hA5, 16'd0, 16'd1}},
      '{8'hA4, ROW_TYPED, '{K_GOOD, 8'h00, 16'd0, 16'd1}}
   };

   run_plan_t run_plans [5] = '{
      '{32'hFFFF_FFFF, 16'd1,     61, 0,  150},
      '{32'h0000_0000, 16'hFFFF,  0,  61, 150},
      '{32'h3C5A_A5C3, 16'd0,     27, 27, 100},
      '{32'h5A3C_C3A5, 16'd37,    27, 27, 150},
      '{32'h91EB_FA58, 16'd24,    0,  0,  100}
   };

   sync_word_packet_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic bit deframe_byte(input logic [7:0] rx, output deframer_out_t res);
      logic [7:0] want;
      bit         was_busy;
      want = cfg_sync[8*(3-match_count) +: 8];
      res  = NO_RESULT;
      if (rx == want) begin
         match_count++;
         if (match_count == 4) begin
            was_busy    = (fr_phase != PH_IDLE);
            res         = '{K_ABORT, 8'h00, 16'd0, decl_len};
            match_count = 0;
            fr_phase    = PH_LEN_LO;
            run_xor     = 8'h00;
            decl_len    = 16'd0;
            body_cnt    = 16'd0;
            return was_busy;
         end
      end else begin
         match_count = 0;
      end
      case (fr_phase)
         PH_LEN_LO: begin
            decl_len = {8'h00, rx};
            run_xor ^= rx;
            fr_phase = PH_LEN_HI;
            return 1'b0;
         end
         PH_LEN_HI: begin
            decl_len[15:8] = rx;
            run_xor ^= rx;
            if (decl_len == 16'd0 || decl_len > cfg_max) begin
               fr_phase    = PH_IDLE;
               match_count = 0;
            end else begin
               fr_phase = PH_BODY;
               body_cnt = 16'd0;
            end
            return 1'b0;
         end
         PH_BODY: begin
            res = '{K_BODY, rx, body_cnt, decl_len};
            body_cnt++;
            run_xor ^= rx;
            if (body_cnt == decl_len) fr_phase = PH_CHECK;
            return 1'b1;
         end
         PH_CHECK: begin
            res         = '{(rx == run_xor) ? K_GOOD : K_BAD, 8'h00, 16'd0, decl_len};
            fr_phase    = PH_IDLE;
            match_count = 0;
            return 1'b1;
         end
         default: begin
            fr_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   // returns just after the rising edge that accepted the item
   task automatic send_item(input logic [7:0] rx);
      @(negedge clock);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic feed_byte(input logic [7:0] rx);
      deframer_out_t res;
      send_item(rx);
      if (deframe_byte(rx, res)) pending_results.push_back(res);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_registers(input logic [31:0] sync_word, input logic [15:0] max_length);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SYNC_WORD;
      csr_wdata <= sync_word;
      @(negedge clock);
      csr_addr  <= CSR_MAX_LENGTH;
      csr_wdata <= {16'h0000, max_length};
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_sync = sync_word;
      cfg_max  = max_length;
   endtask

   // one frame, mostly well formed; otherwise noise, a cut-off or a bad length
   task automatic send_random_frame();
      int          sel;
      int          pick;
      int          n_body;
      int          len_cap;
      logic [15:0] len;
      logic [7:0]  sum;
      logic [7:0]  rx;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         repeat ($urandom_range(1, 6)) feed_byte(8'($urandom));
         return;
      end
      for (int i = 0; i < 4; i++) feed_byte(cfg_sync[31-8*i -: 8]);
      if (sel < 16) begin
         if ($urandom_range(0, 1)) feed_byte(8'($urandom));
         return;
      end
      len_cap = (cfg_max == 16'd0) ? 1 : ((cfg_max < 16'd20) ? int'(cfg_max) : 20);
      pick = $urandom_range(0, 11);
      case (pick)
         0:       len = 16'd0;
         1:       len = cfg_max;
         2:       len = cfg_max + 16'd1;
         3:       len = 16'($urandom);
         default: len = 16'($urandom_range(1, len_cap));
      endcase
      feed_byte(len[7:0]);
      feed_byte(len[15:8]);
      if (len == 16'd0 || len > cfg_max) return;
      n_body = int'(len);
      if (len > 16'd48) n_body = $urandom_range(0, 6);
      else if (sel < 24) n_body = $urandom_range(0, int'(len) - 1);
      sum = len[7:0] ^ len[15:8];
      for (int i = 0; i < n_body; i++) begin
         rx = 8'($urandom);
         sum ^= rx;
         feed_byte(rx);
      end
      if (n_body != int'(len)) return;
      feed_byte(($urandom_range(0, 3) != 0) ? sum : 8'($urandom));
   endtask

   task automatic run_random(input int byte_count);
      int target;
      target = bytes_sent + byte_count;
      while (bytes_sent < target) begin
         send_random_frame();
         if ($urandom_range(0, 49) == 0) drain_results();
      end
   endtask

   always @(posedge clock) begin
      deframer_out_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d data_byte %0h", rsp_tuser, rsp_tdata[7:0]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser != want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] != want.data_byte) begin
               $error("data_byte: expected %0h, got %0h", want.data_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[23:8] != want.byte_index) begin
               $error("byte_index: expected %0d, got %0d", want.byte_index, rsp_tdata[23:8]);
               error_count++;
            end
            if (rsp_tdata[39:24] != want.frame_length) begin
               $error("frame_length: expected %0d, got %0d",
                      want.frame_length, rsp_tdata[39:24]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      deframer_out_t res;
      cfg_sync    = SYNC_WORD_RESET;
      cfg_max     = MAX_LENGTH_RESET;
      fr_phase    = PH_IDLE;
      match_count = 0;
      run_xor     = 8'h00;
      decl_len    = 16'd0;
      body_cnt    = 16'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (frame_rows[i]) begin
         send_item(frame_rows[i].rx);
         if (deframe_byte(frame_rows[i].rx, res) && frame_rows[i].mode == ROW_PREDICT)
            pending_results.push_back(res);
         if (frame_rows[i].mode == ROW_TYPED) pending_results.push_back(frame_rows[i].res);
      end
      run_random(150);

      foreach (run_plans[p]) begin
         drain_results();
         set_registers(run_plans[p].sync_word, run_plans[p].max_length);
         send_idle_pct = run_plans[p].send_idle_pct;
         stall_pct     = run_plans[p].stall_pct;
         run_random(run_plans[p].byte_count);
      end

      drain_results();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
sv/swpd_pkg.sv
sv/swpd_in_stage.sv
sv/swpd_frame.sv
sv/swpd_out_stage.sv
sv/sync_word_packet_deframer_unit.sv
bench/sync_word_packet_deframer_unit_test.sv
